// ----- src/cbc1_pkg.sv -----
// Package for the type-1 cartridge bank controller: widths, address region
// codes, register indexes, sequencer states and the structs shared between modules.
// No dependencies.
`timescale 1ns / 1ps

package cbc1_pkg;

   // Field widths
   localparam int ADDR_W     = 15;
   localparam int DATA_W     = 8;
   localparam int BANK_W     = 7;
   localparam int RAM_BANK_W = 2;
   localparam int ROM_CNT_W  = 8;
   localparam int RAM_CNT_W  = 3;
   localparam int CSR_IDX_W  = 2;

   // Remainder unit: one dividend bit per step
   localparam int REM_STEPS = BANK_W;
   localparam int CNT_W     = $clog2(REM_STEPS);

   // Address regions, taken from write_address[14:13]
   localparam logic [1:0] REGION_RAM_ENABLE = 2'd0;
   localparam logic [1:0] REGION_ROM_BANK   = 2'd1;
   localparam logic [1:0] REGION_UPPER_BANK = 2'd2;
   localparam logic [1:0] REGION_MODE       = 2'd3;

   localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ROM_BANK_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RAM_BANK_COUNT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MULTICART      = 2'd2;

   localparam logic [ROM_CNT_W-1:0] ROM_CNT_RESET  = 8'd2;
   localparam logic [BANK_W-1:0]    ROM_BANK_RESET = 7'd1;

   // Mapper register set
   typedef struct packed {
      logic                  ram_on;
      logic [BANK_W-1:0]     rom_sel;
      logic [RAM_BANK_W-1:0] upper_bank;
      logic                  mode;
   } bank_state_type;

   // Sequencer to remainder unit
   typedef struct packed {
      logic                 start;
      logic [BANK_W-1:0]    dividend;
      logic [ROM_CNT_W-1:0] divisor;
   } rem_req_type;

   // Remainder unit to sequencer
   typedef struct packed {
      logic              done;
      logic [BANK_W-1:0] remainder;
   } rem_rsp_type;

   typedef enum logic [7:0] {
      ST_IDLE     = 8'b0000_0001,
      ST_SW_GO    = 8'b0000_0010,
      ST_SW_WAIT  = 8'b0000_0100,
      ST_FX_GO    = 8'b0000_1000,
      ST_FX_WAIT  = 8'b0001_0000,
      ST_RAM_GO   = 8'b0010_0000,
      ST_RAM_WAIT = 8'b0100_0000,
      ST_EMIT     = 8'b1000_0000
   } seq_state_type;

endpackage

// ----- src/cbc1_req_if.sv -----
// Input channel: one CPU write into the cartridge ROM area per item.
// Depends on cbc1_pkg.
`timescale 1ns / 1ps

interface cbc1_req_if import cbc1_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [ADDR_W-1:0] write_address;
   logic [DATA_W-1:0] write_value;

   modport source (output valid, write_address, write_value, input ready);
   modport sink   (input valid, write_address, write_value, output ready);
endinterface

// ----- src/cbc1_rsp_if.sv -----
// Result channel: bank mapping after each write.
// Depends on cbc1_pkg.
`timescale 1ns / 1ps

interface cbc1_rsp_if import cbc1_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [BANK_W-1:0]     fixed_area_bank;
   logic [BANK_W-1:0]     switch_area_bank;
   logic [RAM_BANK_W-1:0] ram_bank_out;
   logic                  ram_mapped;

   modport source (output valid, fixed_area_bank, switch_area_bank, ram_bank_out,
                   ram_mapped, input ready);
   modport sink   (input valid, fixed_area_bank, switch_area_bank, ram_bank_out,
                   ram_mapped, output ready);
endinterface

// ----- src/cbc1_csr_if.sv -----
// Configuration write channel: register index and write data.
// Depends on cbc1_pkg.
`timescale 1ns / 1ps

interface cbc1_csr_if import cbc1_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [DATA_W-1:0]    wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface

// ----- src/cbc1_bank_regs.sv -----
// Mapper register set: decodes CPU writes into the RAM enable flag, ROM bank,
// upper bank and banking mode. Depends on cbc1_pkg.
`timescale 1ns / 1ps

module cbc1_bank_regs import cbc1_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] write_address,
   input  logic [DATA_W-1:0] write_value,
   input  logic              multicart,
   output bank_state_type    bank
);

   bank_state_type bank_ff, bank_in;
   logic [4:0]     low5;

   // Decode the write by address region
   always_comb begin
      bank_in = bank_ff;
      low5    = (write_value[4:0] == 5'd0) ? 5'd1 : write_value[4:0];
      if (wr_en) begin
         case (write_address[ADDR_W-1:ADDR_W-2])
            REGION_RAM_ENABLE: begin
               bank_in.ram_on = (write_value[3:0] == RAM_ENABLE_KEY);
            end
            REGION_ROM_BANK: begin
               if (multicart) begin
                  bank_in.rom_sel = {bank_ff.rom_sel[6:4], low5[3:0]};
               end else begin
                  bank_in.rom_sel = {bank_ff.rom_sel[6:5], low5};
               end
            end
            REGION_UPPER_BANK: begin
               bank_in.upper_bank = write_value[RAM_BANK_W-1:0];
               if (multicart) begin
                  bank_in.rom_sel = {1'b0, write_value[1:0], bank_ff.rom_sel[3:0]};
               end else begin
                  bank_in.rom_sel = {write_value[1:0], bank_ff.rom_sel[4:0]};
               end
            end
            REGION_MODE: begin
               bank_in.mode = write_value[0];
            end
            default: begin
               bank_in = bank_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_ff.ram_on     <= 1'b0;
         bank_ff.rom_sel    <= ROM_BANK_RESET;
         bank_ff.upper_bank <= '0;
         bank_ff.mode       <= 1'b0;
      end else begin
         bank_ff <= bank_in;
      end
   end

   assign bank = bank_ff;

endmodule

// ----- src/cbc1_rem_unit.sv -----
// Shared restoring remainder unit: one dividend bit per cycle. A zero divisor
// returns the dividend. Depends on cbc1_pkg.
`timescale 1ns / 1ps

module cbc1_rem_unit import cbc1_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  rem_req_type rem_req,
   output rem_rsp_type rem_rsp
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [BANK_W-1:0]    dvd_ff, dvd_in;
   logic [ROM_CNT_W-1:0] dvs_ff, dvs_in;
   logic [ROM_CNT_W-1:0] rem_ff, rem_in;
   logic [ROM_CNT_W:0]   trial;
   logic [ROM_CNT_W:0]   diff;

   // Shift in the next dividend bit, subtract when it fits
   always_comb begin
      trial   = {rem_ff, dvd_ff[BANK_W-1]};
      diff    = trial - {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      if (busy_ff) begin
         dvd_in = {dvd_ff[BANK_W-2:0], 1'b0};
         rem_in = (trial >= {1'b0, dvs_ff}) ? diff[ROM_CNT_W-1:0] : trial[ROM_CNT_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (rem_req.start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(REM_STEPS - 1);
         dvd_in  = rem_req.dividend;
         dvs_in  = rem_req.divisor;
         rem_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Operands and partial remainder
   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
   end

   assign rem_rsp.done      = done_ff;
   assign rem_rsp.remainder = rem_ff[BANK_W-1:0];

   // Done only ever follows the last busy step
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("remainder done without a preceding step");

   // A finished remainder is below a nonzero divisor
   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      (done_ff && dvs_ff != '0) |-> (rem_ff < dvs_ff))
      else $error("remainder not below divisor");

endmodule

// ----- src/cartridge_bank_controller_type1.sv -----
// Top level of the type-1 cartridge bank controller: configuration registers,
// sequencer and result register. Depends on cbc1_pkg, the channel interfaces,
// cbc1_bank_regs and cbc1_rem_unit.
//
//   channel  | dir | payload                                           | accepted when
//   req_ch   | in  | write_address, write_value                        | valid && ready
//   rsp_ch   | out | fixed_area_bank, switch_area_bank, ram_bank_out,  | valid && ready
//            |     | ram_mapped                                        |
//   csr_ch   | in  | index, wdata                                      | valid && ready
//
// Each accepted item makes three passes through the shared remainder unit
// (switchable bank, fixed bank, RAM bank), and the result register is loaded from
// the result state. A new item is accepted only back in the idle state, after the
// result register has been loaded. The unit retires one bit a cycle.
// Synchronous active-high reset; configuration writes are always ready.
// A result waiting on rsp_ch does not block the next item; the sequencer holds in
// its last state only while the result register is still full.
`timescale 1ns / 1ps

module cartridge_bank_controller_type1 import cbc1_pkg::*; (
   input logic        clock,
   input logic        reset,
   cbc1_req_if.sink   req_ch,
   cbc1_rsp_if.source rsp_ch,
   cbc1_csr_if.sink   csr_ch
);

   seq_state_type         state_ff, state_in;
   logic [ROM_CNT_W-1:0]  rom_count_ff, rom_count_in;
   logic [RAM_CNT_W-1:0]  ram_count_ff, ram_count_in;
   logic                  multi_ff, multi_in;
   logic [BANK_W-1:0]     sw_bank_ff, sw_bank_in;
   logic [BANK_W-1:0]     fx_bank_ff, fx_bank_in;
   logic [RAM_BANK_W-1:0] ram_rem_ff, ram_rem_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [BANK_W-1:0]     rsp_fixed_ff, rsp_fixed_in;
   logic [BANK_W-1:0]     rsp_switch_ff, rsp_switch_in;
   logic [RAM_BANK_W-1:0] rsp_ram_ff, rsp_ram_in;
   logic                  rsp_mapped_ff, rsp_mapped_in;

   logic                  req_accept;
   logic                  rsp_free;
   logic                  mapped;
   logic [BANK_W-1:0]     fixed_dividend;
   bank_state_type        bank;
   rem_req_type           rem_req;
   rem_rsp_type           rem_rsp;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_accept   = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;
   assign rsp_free     = !rsp_valid_ff || rsp_ch.ready;

   // Configuration registers
   always_comb begin
      rom_count_in = rom_count_ff;
      ram_count_in = ram_count_ff;
      multi_in     = multi_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_ROM_BANK_COUNT: rom_count_in = csr_ch.wdata;
            CSR_RAM_BANK_COUNT: ram_count_in = csr_ch.wdata[RAM_CNT_W-1:0];
            CSR_MULTICART:      multi_in     = csr_ch.wdata[0];
            default:            rom_count_in = rom_count_ff;
         endcase
      end
   end

   cbc1_bank_regs u_bank_regs (
      .clock         (clock),
      .reset         (reset),
      .wr_en         (req_accept),
      .write_address (req_ch.write_address),
      .write_value   (req_ch.write_value),
      .multicart     (multi_ff),
      .bank          (bank)
   );

   // Upper bits at the position that the wiring gives, zero in mode 0
   always_comb begin
      if (!bank.mode) begin
         fixed_dividend = '0;
      end else if (multi_ff) begin
         fixed_dividend = {1'b0, bank.upper_bank, 4'b0000};
      end else begin
         fixed_dividend = {bank.upper_bank, 5'b00000};
      end
   end

   // Select the operands for the shared remainder unit
   always_comb begin
      rem_req.start = (state_ff == ST_SW_GO) || (state_ff == ST_FX_GO) ||
                      (state_ff == ST_RAM_GO);
      case (state_ff)
         ST_FX_GO: begin
            rem_req.dividend = fixed_dividend;
            rem_req.divisor  = rom_count_ff;
         end
         ST_RAM_GO: begin
            rem_req.dividend = {{(BANK_W-RAM_BANK_W){1'b0}}, bank.upper_bank};
            rem_req.divisor  = {{(ROM_CNT_W-RAM_CNT_W){1'b0}}, ram_count_ff};
         end
         default: begin
            rem_req.dividend = bank.rom_sel;
            rem_req.divisor  = rom_count_ff;
         end
      endcase
   end

   cbc1_rem_unit u_rem_unit (
      .clock   (clock),
      .reset   (reset),
      .rem_req (rem_req),
      .rem_rsp (rem_rsp)
   );

   assign mapped = bank.ram_on && (ram_count_ff != '0);

   // Sequencer: three remainder passes, then load the result register
   always_comb begin
      state_in      = state_ff;
      sw_bank_in    = sw_bank_ff;
      fx_bank_in    = fx_bank_ff;
      ram_rem_in    = ram_rem_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_fixed_in  = rsp_fixed_ff;
      rsp_switch_in = rsp_switch_ff;
      rsp_ram_in    = rsp_ram_ff;
      rsp_mapped_in = rsp_mapped_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_SW_GO;
            end
         end
         ST_SW_GO:  state_in = ST_SW_WAIT;
         ST_SW_WAIT: begin
            if (rem_rsp.done) begin
               sw_bank_in = rem_rsp.remainder;
               state_in   = ST_FX_GO;
            end
         end
         ST_FX_GO:  state_in = ST_FX_WAIT;
         ST_FX_WAIT: begin
            if (rem_rsp.done) begin
               fx_bank_in = rem_rsp.remainder;
               state_in   = ST_RAM_GO;
            end
         end
         ST_RAM_GO: state_in = ST_RAM_WAIT;
         ST_RAM_WAIT: begin
            if (rem_rsp.done) begin
               ram_rem_in = rem_rsp.remainder[RAM_BANK_W-1:0];
               state_in   = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_fixed_in  = fx_bank_ff;
               rsp_switch_in = sw_bank_ff;
               rsp_mapped_in = mapped;
               rsp_ram_in    = (mapped && (ram_count_ff > 3'd1) && bank.mode) ?
                               ram_rem_ff : '0;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rom_count_ff <= ROM_CNT_RESET;
         ram_count_ff <= '0;
         multi_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rom_count_ff <= rom_count_in;
         ram_count_ff <= ram_count_in;
         multi_ff     <= multi_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Intermediate banks and result payload
   always_ff @(posedge clock) begin
      sw_bank_ff    <= sw_bank_in;
      fx_bank_ff    <= fx_bank_in;
      ram_rem_ff    <= ram_rem_in;
      rsp_fixed_ff  <= rsp_fixed_in;
      rsp_switch_ff <= rsp_switch_in;
      rsp_ram_ff    <= rsp_ram_in;
      rsp_mapped_ff <= rsp_mapped_in;
   end

   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.fixed_area_bank  = rsp_fixed_ff;
   assign rsp_ch.switch_area_bank = rsp_switch_ff;
   assign rsp_ch.ram_bank_out     = rsp_ram_ff;
   assign rsp_ch.ram_mapped       = rsp_mapped_ff;

   // An accepted item always starts with the switchable bank pass
   a_accept_starts_pass: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == ST_SW_GO))
      else $error("accepted item did not start the remainder passes");

   // A new result appears only out of the result state
   a_result_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EMIT))
      else $error("result raised outside the result state");

endmodule

// ----- tb/tb_top.sv -----
// Self-checking bench for cartridge_bank_controller_type1. It drives CPU writes and
// register writes, predicts the bank mapping after each write and checks every result.
// Depends on cbc1_pkg, the three channel interfaces and the controller RTL.
`timescale 1ns / 1ps

module tb_top;
   import cbc1_pkg::*;

   localparam int QUIET_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 40;
   localparam int PHASE_ITEMS   = 50;
   localparam int NUM_PHASES    = 8;
   localparam int REPORT_MAX    = 10;

   typedef struct packed {
      logic [ADDR_W-1:0] address;
      logic [DATA_W-1:0] value;
   } cpu_write_type;

   typedef struct packed {
      logic [BANK_W-1:0]     fixed_bank;
      logic [BANK_W-1:0]     switch_bank;
      logic [RAM_BANK_W-1:0] ram_sel;
      logic                  ram_mapped;
   } bank_map_type;

   logic clock;
   logic reset;

   cbc1_req_if req_bus ();
   cbc1_rsp_if rsp_bus ();
   cbc1_csr_if csr_bus ();

   cartridge_bank_controller_type1 DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   // Mirror of the mapper registers and configuration
   logic                 bank_ram_en;
   logic [BANK_W-1:0]    bank_rom;
   logic [1:0]           bank_upper;
   logic                 bank_mode;
   logic [ROM_CNT_W-1:0] cfg_rom_count;
   logic [RAM_CNT_W-1:0] cfg_ram_count;
   logic                 cfg_multicart;

   cpu_write_type pending_writes[$];
   bank_map_type  expected_maps[$];

   int unsigned req_gap_max;
   int unsigned rsp_stall_max;
   int unsigned mismatch_count;
   int unsigned writes_accepted;
   int unsigned maps_checked;
   int unsigned csr_writes;
   int unsigned quiet_cycles;

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // Wrap a ROM bank number by the configured bank count; zero count leaves it as is
   function automatic logic [BANK_W-1:0] wrap_rom_num(input logic [BANK_W-1:0] bank);
      if (cfg_rom_count == '0)
         return bank;
      return BANK_W'(int'(bank) % int'(cfg_rom_count));
   endfunction

   // Apply one CPU write to the mirrored registers and work out the mapping after it
   function automatic bank_map_type predict_mapping(input cpu_write_type w);
      bank_map_type      m;
      logic [4:0]        low;
      logic [BANK_W-1:0] outer;
      m = '0;
      case (w.address[ADDR_W-1 -: 2])
         REGION_RAM_ENABLE: bank_ram_en = (w.value[3:0] == RAM_ENABLE_KEY);
         REGION_ROM_BANK: begin
            low = (w.value[4:0] == 5'd0) ? 5'd1 : w.value[4:0];
            if (cfg_multicart)
               bank_rom = {bank_rom[6:4], low[3:0]};
            else
               bank_rom = {bank_rom[6:5], low};
         end
         REGION_UPPER_BANK: begin
            bank_upper = w.value[1:0];
            if (cfg_multicart)
               bank_rom = {1'b0, bank_upper, bank_rom[3:0]};
            else
               bank_rom = {bank_upper, bank_rom[4:0]};
         end
         REGION_MODE: bank_mode = w.value[0];
         default: ;
      endcase

      // Outer bits sit one place lower under multicart wiring
      outer = cfg_multicart ? {1'b0, bank_upper, 4'b0} : {bank_upper, 5'b0};
      if (bank_mode)
         m.fixed_bank = wrap_rom_num(outer);
      m.switch_bank = wrap_rom_num(bank_rom);
      m.ram_mapped  = bank_ram_en && (cfg_ram_count != '0);
      if (m.ram_mapped && cfg_ram_count > 3'd1 && bank_mode)
         m.ram_sel = RAM_BANK_W'(int'(bank_upper) % int'(cfg_ram_count));
      return m;
   endfunction

   // Write sender: hold the item until accepted, then idle for a drawn number of cycles
   int unsigned hold_cycles;
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid         <= 1'b0;
         req_bus.write_address <= '0;
         req_bus.write_value   <= '0;
         hold_cycles = 0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (hold_cycles > 0) begin
            req_bus.valid <= 1'b0;
            hold_cycles--;
         end else if (pending_writes.size() != 0) begin
            cpu_write_type w;
            w = pending_writes.pop_front();
            req_bus.write_address <= w.address;
            req_bus.write_value   <= w.value;
            req_bus.valid         <= 1'b1;
            hold_cycles = $urandom_range(0, req_gap_max);
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Result receiver: stall for a drawn number of cycles after each item
   int unsigned stall_cycles;
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_cycles = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready)
            stall_cycles = $urandom_range(0, rsp_stall_max);
         if (stall_cycles > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_cycles--;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Monitor: track register writes, predict on each accepted write, check each result
   always @(posedge clock) begin
      if (reset) begin
         bank_ram_en   = 1'b0;
         bank_rom      = ROM_BANK_RESET;
         bank_upper    = '0;
         bank_mode     = 1'b0;
         cfg_rom_count = ROM_CNT_RESET;
         cfg_ram_count = '0;
         cfg_multicart = 1'b0;
      end else begin
         if (csr_bus.valid && csr_bus.ready) begin
            csr_writes++;
            case (csr_bus.index)
               CSR_ROM_BANK_COUNT: cfg_rom_count = csr_bus.wdata;
               CSR_RAM_BANK_COUNT: cfg_ram_count = csr_bus.wdata[RAM_CNT_W-1:0];
               CSR_MULTICART:      cfg_multicart = csr_bus.wdata[0];
               default: ;
            endcase
         end
         if (req_bus.valid && req_bus.ready) begin
            writes_accepted++;
            expected_maps.push_back(predict_mapping({req_bus.write_address,
                                                     req_bus.write_value}));
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            bank_map_type got;
            bank_map_type want;
            got = {rsp_bus.fixed_area_bank, rsp_bus.switch_area_bank,
                   rsp_bus.ram_bank_out, rsp_bus.ram_mapped};
            if (expected_maps.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_MAX)
                  $display("%0t: unexpected result: fixed %0d switch %0d ram %0d mapped %0d",
                           $realtime, got.fixed_bank, got.switch_bank, got.ram_sel,
                           got.ram_mapped);
            end else begin
               want = expected_maps.pop_front();
               maps_checked++;
               if (got.fixed_bank != want.fixed_bank || got.switch_bank != want.switch_bank ||
                   got.ram_sel != want.ram_sel || got.ram_mapped != want.ram_mapped) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_MAX) begin
                     $display("%0t: mapping %0d mismatch: expected fixed %0d switch %0d",
                              $realtime, maps_checked, want.fixed_bank, want.switch_bank);
                     $display("   ram %0d mapped %0d, got fixed %0d switch %0d ram %0d mapped %0d",
                              want.ram_sel, want.ram_mapped, got.fixed_bank,
                              got.switch_bank, got.ram_sel, got.ram_mapped);
                  end
               end
            end
         end
      end
   end

   // Watchdog: end the run when no channel moves an item for too long
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Timeout after %0d cycles without progress", QUIET_LIMIT);
         $display("cartridge_bank_controller_type1 verification failed");
         $finish;
      end
   end

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
      csr_bus.index <= idx;
      csr_bus.wdata <= data;
      csr_bus.valid <= 1'b1;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic queue_write(input logic [ADDR_W-1:0] address,
                              input logic [DATA_W-1:0] value);
      pending_writes.push_back({address, value});
   endtask

   // Hold until every queued write is sent and every mapping has come back;
   // sample on the falling edge so that the sender's updates have settled
   task automatic drain();
      while (pending_writes.size() != 0 || req_bus.valid || expected_maps.size() != 0)
         @(negedge clock);
      @(posedge clock);
   endtask

   // Mostly bank switching; half the enable writes carry the unlock key
   function automatic cpu_write_type random_write();
      cpu_write_type w;
      logic [1:0]    region;
      int unsigned   pick;
      pick = $urandom_range(0, 99);
      if (pick < 30)
         region = REGION_RAM_ENABLE;
      else if (pick < 60)
         region = REGION_ROM_BANK;
      else if (pick < 85)
         region = REGION_UPPER_BANK;
      else
         region = REGION_MODE;
      w.address = {region, (ADDR_W-2)'($urandom)};
      w.value   = DATA_W'($urandom);
      if (region == REGION_RAM_ENABLE && $urandom_range(0, 1) == 1)
         w.value[3:0] = RAM_ENABLE_KEY;
      return w;
   endfunction

   int unsigned rom_counts  [NUM_PHASES] = '{2, 128, 0, 1, 255, 64, 2, 5};
   int unsigned ram_counts  [NUM_PHASES] = '{0, 4, 1, 7, 3, 2, 0, 5};
   int unsigned multi_sel   [NUM_PHASES] = '{0, 0, 1, 0, 1, 0, 0, 1};

   initial begin
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.write_address = '0;
      req_bus.write_value   = '0;
      rsp_bus.ready      = 1'b0;
      csr_bus.valid      = 1'b0;
      csr_bus.index      = '0;
      csr_bus.wdata      = '0;
      req_gap_max        = 0;
      rsp_stall_max      = 0;
      mismatch_count     = 0;
      writes_accepted    = 0;
      maps_checked       = 0;
      csr_writes         = 0;
      quiet_cycles       = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset mapping: RAM cannot map with no RAM banks
      queue_write(15'h7FFF, 8'h00);
      queue_write(15'h0000, 8'h0A);
      drain();

      // Full-size cartridge, normal wiring
      write_csr(CSR_ROM_BANK_COUNT, 8'd128);
      write_csr(CSR_RAM_BANK_COUNT, 8'd4);
      queue_write(15'h1FFF, 8'hFA);
      queue_write(15'h2000, 8'h00);
      queue_write(15'h3FFF, 8'hFF);
      queue_write(15'h4000, 8'hFF);
      queue_write(15'h6000, 8'h01);
      queue_write(15'h5FFF, 8'h02);
      queue_write(15'h2000, 8'h20);
      queue_write(15'h0000, 8'h0B);
      queue_write(15'h7FFF, 8'hFE);
      queue_write(15'h1000, 8'h5A);
      drain();

      // Switch to multicart wiring with the bank register kept
      write_csr(CSR_MULTICART, 8'h01);
      queue_write(15'h2000, 8'h10);
      queue_write(15'h4000, 8'h03);
      queue_write(15'h6000, 8'h01);
      queue_write(15'h3000, 8'h0F);
      drain();

      // And back again
      write_csr(CSR_MULTICART, 8'hFE);
      queue_write(15'h2000, 8'h1F);
      queue_write(15'h4000, 8'h01);
      drain();

      // Random phases, one setting each; phase 6 draws its own
      for (int p = 0; p < NUM_PHASES; p++) begin
         if (p == 6) begin
            rom_counts[p] = $urandom_range(2, 128);
            ram_counts[p] = $urandom_range(0, 7);
            multi_sel[p]  = $urandom_range(0, 1);
         end
         write_csr(CSR_ROM_BANK_COUNT, DATA_W'(rom_counts[p]));
         write_csr(CSR_RAM_BANK_COUNT, DATA_W'(ram_counts[p]));
         write_csr(CSR_MULTICART, DATA_W'(multi_sel[p]));
         req_gap_max   = (p % 3 == 0) ? 0 : 4;
         rsp_stall_max = (p % 2 == 0) ? 4 : 0;
         for (int i = 0; i < PHASE_ITEMS; i++)
            pending_writes.push_back(random_write());
         drain();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_maps.size() != 0) begin
         $display("%0d mappings never arrived", expected_maps.size());
         mismatch_count += expected_maps.size();
      end

      $display("Sent %0d CPU writes and checked %0d bank mappings", writes_accepted,
               maps_checked);
      $display("Covered %0d register writes across %0d random settings, %0d mismatches",
               csr_writes, NUM_PHASES, mismatch_count);
      if (mismatch_count == 0)
         $display("cartridge_bank_controller_type1 verification clean");
      else
         $display("cartridge_bank_controller_type1 verification failed");
      $finish;
   end

endmodule
